>>> src/fmdc_pkg.sv
package fmdc_pkg;

    // default array sizes
    localparam int MAX_INNER_DEF = 16;
    localparam int MAX_OUTER_DEF = 16;

    // hash constants
    localparam logic [63:0] MOD_P    = 64'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FMIX_C1  = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] FMIX_C2  = 64'hc4ce_b9fe_1a85_ec53;
    localparam int          FMIX_SH  = 33;
    localparam logic [6:0]  RANK_ZERO = 7'd65;
    localparam logic [6:0]  RANK_TERM_MAX = 7'd32;

    // register reset values
    localparam logic [4:0]  INNER_RST = 5'd16;
    localparam logic [4:0]  OUTER_RST = 5'd16;
    localparam logic [15:0] CORR_RST  = 16'd50693;

    // configuration register indexes
    localparam logic [1:0] CFG_INNER = 2'd0;
    localparam logic [1:0] CFG_OUTER = 2'd1;
    localparam logic [1:0] CFG_CORR  = 2'd2;

    // input function codes
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_ADD  = 2'd1;
    localparam logic [1:0] FUNC_EST  = 2'd2;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_A_RD,
        ST_A_MUL,
        ST_A_WAIT1,
        ST_A_FOLD,
        ST_A_MOD,
        ST_A_M1,
        ST_A_W2,
        ST_A_M2,
        ST_A_W3,
        ST_A_LZ,
        ST_A_UPD,
        ST_E_RD,
        ST_E_ACC,
        ST_E_DIV,
        ST_E_DWAIT,
        ST_E_WR,
        ST_M_RI,
        ST_M_LI,
        ST_M_RJ,
        ST_M_CMP,
        ST_M_EVAL,
        ST_OUT
    } state_t;

    // leading zeros of a nonzero byte
    function automatic logic [2:0] lzc8(input logic [7:0] b);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = 3'(7 - i);
        end
        return r;
    endfunction

endpackage

>>> src/fmdc_ram.sv
module fmdc_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    output logic [WIDTH-1:0]  rdata_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> src/fmdc_mul.sv
module fmdc_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] prod
);

    logic [63:0] a_reg, b_reg, acc_reg, pr_reg;
    logic [2:0]  step_reg;
    logic        done_reg;
    logic [31:0] ma, mb;

    // one 32x32 multiplier, low 64 bits of a 64x64 product over four steps
    always_comb begin
        unique case (step_reg)
            3'd1:    begin ma = a_reg[31:0];  mb = b_reg[31:0];  end
            3'd2:    begin ma = a_reg[31:0];  mb = b_reg[63:32]; end
            3'd3:    begin ma = a_reg[63:32]; mb = b_reg[31:0];  end
            default: begin ma = a_reg[31:0];  mb = b_reg[31:0];  end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (step_reg == 3'd4);
            if (start) step_reg <= 3'd1;
            else if (step_reg == 3'd4) step_reg <= 3'd0;
            else if (step_reg != 3'd0) step_reg <= step_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        pr_reg <= 64'(ma) * 64'(mb);
        unique case (step_reg)
            3'd2:    acc_reg <= pr_reg;
            3'd3:    acc_reg <= acc_reg + {pr_reg[31:0], 32'd0};
            3'd4:    acc_reg <= acc_reg + {pr_reg[31:0], 32'd0};
            default: acc_reg <= acc_reg;
        endcase
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> src/fmdc_div.sv
module fmdc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [64:0] rem_reg;
    logic [63:0] quo_reg, den_reg;
    logic [6:0]  cnt_reg;
    logic        done_reg;
    logic [64:0] trial;
    logic        fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg[63:0], quo_reg[63]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == 7'd1);
            if (start) cnt_reg <= 7'd64;
            else if (cnt_reg != 7'd0) cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= 65'd0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (cnt_reg != 7'd0) begin
            rem_reg <= fits ? trial - {1'b0, den_reg} : trial;
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> src/fm_distinct_count_sketch.sv
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_func, s_seed_index, s_seed_value, s_item_value
// m_        out        m_valid / m_ready      m_estimate_q16, m_saturated
// cfg_      in         cfg_wr_en (no wait)    cfg_wr_index, cfg_wr_data
//
// A seed load is written as it is accepted and leaves the block idle. An add updates every
// active counter (inner*outer counters) in turn, with an extra step per leading zero byte in
// the hash; the shared 32x32 multiplier runs four passes for each of the three products of a hash.
// An estimate divides per group (64-bit restoring divider, skipped on a zero sum),
// then runs the median rank search over the group estimate memory, then presents
// the result on the output.
// After reset a clearing pass over all MAX_INNER*MAX_OUTER counters zeroes them.
// Reset is synchronous, active low. A finished estimate waits in the output
// register; new transactions are taken meanwhile, a second estimate holds at its end.
module fm_distinct_count_sketch #(
    parameter int MAX_INNER = fmdc_pkg::MAX_INNER_DEF,
    parameter int MAX_OUTER = fmdc_pkg::MAX_OUTER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [8:0]  s_seed_index,
    input  logic [60:0] s_seed_value,
    input  logic [63:0] s_item_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_estimate_q16,
    output logic        m_saturated,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [15:0] cfg_wr_data
);
    import fmdc_pkg::*;

    localparam int CD    = MAX_INNER * MAX_OUTER;
    localparam int SD    = 2 * CD;
    localparam int CA_W  = (CD > 1) ? $clog2(CD) : 1;
    localparam int SA_W  = CA_W + 1;
    localparam int GA_W  = (MAX_OUTER > 1) ? $clog2(MAX_OUTER) : 1;
    localparam int K_W   = $clog2(MAX_INNER + 1);
    localparam int L_W   = $clog2(MAX_OUTER + 1);
    localparam int KL_W  = $clog2(CD + 1);

    state_t state_reg, state_next;

    // configuration
    logic [4:0]  inner_reg, outer_reg;
    logic [15:0] corr_reg;
    logic [K_W-1:0]  k;
    logic [L_W-1:0]  l, mid;
    logic [KL_W-1:0] kl;

    // datapath
    logic [63:0]     item_reg, w_reg, b_reg, sum_reg, numer_reg, est_reg;
    logic [63:0]     cand_reg, v1_reg, v2_reg, res_reg;
    logic [6:0]      crank_reg, rank_reg, lz_reg;
    logic [CA_W-1:0] n_reg, clr_reg;
    logic [K_W-1:0]  c_reg;
    logic [GA_W-1:0] g_reg, i_reg, j_reg, cnt_reg;
    logic            flag_reg;
    logic            m_valid_reg, m_sat_reg;
    logic [63:0]     m_est_reg;

    // memory and unit hookups
    logic            s_acc;
    logic            seed_we;
    logic [SA_W-1:0] seed_waddr, seed_raddr_a, seed_raddr_b;
    logic [60:0]     seed_wdata, seed_a, seed_b;
    logic            ctr_we;
    logic [CA_W-1:0] ctr_waddr, ctr_raddr;
    logic [6:0]      ctr_wdata, ctr_rdata, ctr_unused;
    logic            est_we;
    logic [GA_W-1:0] est_raddr;
    logic [63:0]     est_rdata, est_unused;
    logic            mul_start, mul_done, div_start, div_done;
    logic [63:0]     mul_a, mul_b, mul_p, div_q;

    logic            last_n, last_c, last_g, last_j, last_i, lz_done;
    logic [63:0]     fmix_p, mod_t;

    // clamp the count registers
    always_comb begin
        if (inner_reg == 5'd0)                k = K_W'(1);
        else if (32'(inner_reg) > MAX_INNER)  k = K_W'(MAX_INNER);
        else                                  k = K_W'(inner_reg);
        if (outer_reg == 5'd0)                l = L_W'(1);
        else if (32'(outer_reg) > MAX_OUTER)  l = L_W'(MAX_OUTER);
        else                                  l = L_W'(outer_reg);
    end
    assign kl  = KL_W'(k) * KL_W'(l);
    assign mid = l >> 1;

    assign s_acc   = s_valid && s_ready;
    assign last_n  = int'(n_reg) == int'(kl) - 1;
    assign last_c  = int'(c_reg) == int'(k) - 1;
    assign last_g  = int'(g_reg) == int'(l) - 1;
    assign last_j  = int'(j_reg) == int'(l) - 1;
    assign last_i  = int'(i_reg) == int'(l) - 1;
    assign lz_done = (w_reg == 64'd0) || (w_reg[63:56] != 8'd0);
    assign fmix_p  = mul_p ^ (mul_p >> FMIX_SH);
    assign mod_t   = (w_reg >= MOD_P) ? w_reg - MOD_P : w_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_reg <= INNER_RST;
            outer_reg <= OUTER_RST;
            corr_reg  <= CORR_RST;
        end else if (cfg_wr_en) begin
            priority case (cfg_wr_index)
                CFG_INNER: inner_reg <= cfg_wr_data[4:0];
                CFG_OUTER: outer_reg <= cfg_wr_data[4:0];
                CFG_CORR:  corr_reg  <= cfg_wr_data;
                default:   ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:     if (int'(clr_reg) == CD - 1) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_acc && s_func == FUNC_ADD) state_next = ST_A_RD;
                else if (s_acc && s_func == FUNC_EST) state_next = ST_E_RD;
            end
            ST_A_RD:    state_next = ST_A_MUL;
            ST_A_MUL:   state_next = ST_A_WAIT1;
            ST_A_WAIT1: if (mul_done) state_next = ST_A_FOLD;
            ST_A_FOLD:  state_next = ST_A_MOD;
            ST_A_MOD:   state_next = ST_A_M1;
            ST_A_M1:    state_next = ST_A_W2;
            ST_A_W2:    if (mul_done) state_next = ST_A_M2;
            ST_A_M2:    state_next = ST_A_W3;
            ST_A_W3:    if (mul_done) state_next = ST_A_LZ;
            ST_A_LZ:    if (lz_done) state_next = ST_A_UPD;
            ST_A_UPD:   state_next = last_n ? ST_IDLE : ST_A_RD;
            ST_E_RD:    state_next = ST_E_ACC;
            ST_E_ACC:   state_next = last_c ? ST_E_DIV : ST_E_RD;
            ST_E_DIV:   state_next = (sum_reg == 64'd0) ? ST_E_WR : ST_E_DWAIT;
            ST_E_DWAIT: if (div_done) state_next = ST_E_WR;
            ST_E_WR:    state_next = last_g ? ST_M_RI : ST_E_RD;
            ST_M_RI:    state_next = ST_M_LI;
            ST_M_LI:    state_next = ST_M_RJ;
            ST_M_RJ:    state_next = ST_M_CMP;
            ST_M_CMP:   state_next = last_j ? ST_M_EVAL : ST_M_RJ;
            ST_M_EVAL:  state_next = last_i ? ST_OUT : ST_M_RI;
            ST_OUT:     if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_CLR;
        else          state_reg <= state_next;
    end

    // control outputs
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        seed_we      = s_acc && s_func == FUNC_LOAD && 32'(s_seed_index) < SD;
        seed_waddr   = SA_W'(s_seed_index);
        seed_wdata   = s_seed_value | {60'd0, ~s_seed_index[0]};
        seed_raddr_a = {n_reg, 1'b0};
        seed_raddr_b = {n_reg, 1'b1};
        ctr_raddr    = n_reg;
        ctr_we       = 1'b0;
        ctr_waddr    = n_reg;
        ctr_wdata    = rank_reg;
        est_we       = (state_reg == ST_E_WR);
        est_raddr    = i_reg;
        mul_start    = 1'b0;
        mul_a        = w_reg;
        mul_b        = FMIX_C1;
        div_start    = 1'b0;
        unique case (state_reg)
            ST_CLR: begin
                ctr_we    = 1'b1;
                ctr_waddr = clr_reg;
                ctr_wdata = 7'd0;
            end
            ST_A_MUL: begin
                mul_start = 1'b1;
                mul_a     = {3'd0, seed_a};
                mul_b     = item_reg;
            end
            ST_A_M1:  mul_start = 1'b1;
            ST_A_M2: begin
                mul_start = 1'b1;
                mul_b     = FMIX_C2;
            end
            ST_A_UPD: ctr_we = rank_reg > crank_reg;
            ST_E_DIV: div_start = (sum_reg != 64'd0);
            ST_M_RJ:  est_raddr = j_reg;
            default:  ;
        endcase
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                item_reg  <= s_item_value;
                sum_reg   <= 64'd0;
                numer_reg <= {8'd0, 24'(corr_reg) * 24'(k), 32'd0};
            end
            ST_A_MUL: begin
                b_reg     <= {3'd0, seed_b};
                crank_reg <= ctr_rdata;
            end
            ST_A_WAIT1: if (mul_done) w_reg <= mul_p + b_reg;
            ST_A_FOLD:  w_reg <= {3'd0, w_reg[60:0]} + {61'd0, w_reg[63:61]};
            ST_A_MOD:   w_reg <= mod_t ^ (mod_t >> FMIX_SH);
            ST_A_W2:    if (mul_done) w_reg <= fmix_p;
            ST_A_W3: begin
                if (mul_done) w_reg <= fmix_p;
                lz_reg <= 7'd0;
            end
            ST_A_LZ: begin
                if (w_reg == 64'd0) begin
                    rank_reg <= RANK_ZERO;
                end else if (w_reg[63:56] == 8'd0) begin
                    w_reg  <= w_reg << 8;
                    lz_reg <= lz_reg + 7'd8;
                end else begin
                    rank_reg <= lz_reg + 7'(lzc8(w_reg[63:56])) + 7'd1;
                end
            end
            ST_E_ACC: begin
                if (ctr_rdata <= RANK_TERM_MAX)
                    sum_reg <= sum_reg + (64'd1 << (6'd32 - ctr_rdata[5:0]));
            end
            ST_E_DIV:   est_reg <= 64'hFFFF_FFFF_FFFF_FFFF;
            ST_E_DWAIT: if (div_done) est_reg <= div_q;
            ST_E_WR:    sum_reg <= 64'd0;
            ST_M_LI:    cand_reg <= est_rdata;
            ST_M_EVAL: begin
                if (int'(cnt_reg) == int'(mid))     v2_reg <= cand_reg;
                if (int'(cnt_reg) == int'(mid) - 1) v1_reg <= cand_reg;
            end
            default: ;
        endcase
    end

    // median of the group estimates
    always_comb begin
        if (l[0]) res_reg = v2_reg;
        else      res_reg = (v1_reg >> 1) + (v2_reg >> 1) + {63'd0, v1_reg[0] & v2_reg[0]};
    end

    // counters and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            n_reg       <= '0;
            c_reg       <= '0;
            g_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            cnt_reg     <= '0;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready)                      m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLR:  clr_reg <= clr_reg + CA_W'(1);
                ST_IDLE: begin
                    n_reg    <= '0;
                    c_reg    <= '0;
                    g_reg    <= '0;
                    flag_reg <= 1'b0;
                end
                ST_A_UPD: n_reg <= n_reg + CA_W'(1);
                ST_E_ACC: begin
                    if (!last_c) begin
                        n_reg <= n_reg + CA_W'(1);
                        c_reg <= c_reg + K_W'(1);
                    end
                end
                ST_E_DIV: if (sum_reg == 64'd0) flag_reg <= 1'b1;
                ST_E_WR: begin
                    n_reg <= n_reg + CA_W'(1);
                    c_reg <= '0;
                    g_reg <= g_reg + GA_W'(1);
                    i_reg <= '0;
                end
                ST_M_LI: begin
                    j_reg   <= '0;
                    cnt_reg <= '0;
                end
                ST_M_CMP: begin
                    if (est_rdata < cand_reg || (est_rdata == cand_reg && j_reg < i_reg))
                        cnt_reg <= cnt_reg + GA_W'(1);
                    j_reg <= j_reg + GA_W'(1);
                end
                ST_M_EVAL: i_reg <= i_reg + GA_W'(1);
                default: ;
            endcase
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_est_reg <= res_reg;
            m_sat_reg <= flag_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_estimate_q16 = m_est_reg;
    assign m_saturated    = m_sat_reg;

    fmdc_ram #(.WIDTH(61), .DEPTH(SD), .ADDR_W(SA_W)) u_seed_ram (
        .aclk    (aclk),
        .we      (seed_we),
        .waddr   (seed_waddr),
        .wdata   (seed_wdata),
        .raddr_a (seed_raddr_a),
        .rdata_a (seed_a),
        .raddr_b (seed_raddr_b),
        .rdata_b (seed_b)
    );

    fmdc_ram #(.WIDTH(7), .DEPTH(CD), .ADDR_W(CA_W)) u_ctr_ram (
        .aclk    (aclk),
        .we      (ctr_we),
        .waddr   (ctr_waddr),
        .wdata   (ctr_wdata),
        .raddr_a (ctr_raddr),
        .rdata_a (ctr_rdata),
        .raddr_b (ctr_raddr),
        .rdata_b (ctr_unused)
    );

    fmdc_ram #(.WIDTH(64), .DEPTH(MAX_OUTER), .ADDR_W(GA_W)) u_est_ram (
        .aclk    (aclk),
        .we      (est_we),
        .waddr   (g_reg),
        .wdata   (est_reg),
        .raddr_a (est_raddr),
        .rdata_a (est_rdata),
        .raddr_b (est_raddr),
        .rdata_b (est_unused)
    );

    fmdc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_p)
    );

    fmdc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (numer_reg),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

>>> src/fmdc_checker.sv
module fmdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_func,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_estimate_q16,
    input logic        m_saturated
);
    import fmdc_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_estimate_q16) && $stable(m_saturated))
        else $error("result changed while stalled");

    // no result pending right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a seed load never creates a result
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_LOAD && !m_valid |=> !m_valid)
        else $error("seed load produced a result");

    // an add or an estimate keeps the input closed for the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func == FUNC_ADD || s_func == FUNC_EST) |=> !s_ready)
        else $error("input open during multicycle transaction");

endmodule

bind fm_distinct_count_sketch fmdc_checker u_fmdc_checker (.*);

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import fmdc_pkg::*;

    localparam logic [1:0] FUNC_NOP = 2'd3;   // undefined code, dropped by the block
    localparam logic [1:0] CFG_NONE = 2'd3;   // register index past the end
    localparam int         N_SLOTS  = 2 * MAX_INNER_DEF * MAX_OUTER_DEF;
    localparam int         N_CNT    = MAX_INNER_DEF * MAX_OUTER_DEF;
    localparam logic [60:0] SEED_ONES = {61{1'b1}};

    typedef struct packed {
        logic [63:0] estimate;
        logic        sat;
    } est_t;

    // one directed row: either a register write or a transaction
    typedef struct {
        bit          is_cfg;
        logic [1:0]  func_or_reg;
        logic [8:0]  slot;
        logic [60:0] seed;
        logic [63:0] elem;
        bit          typed;
        est_t        want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = '0;
    logic [8:0]  s_seed_index = '0;
    logic [60:0] s_seed_value = '0;
    logic [63:0] s_item_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_estimate_q16;
    logic        m_saturated;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_index = '0;
    logic [15:0] cfg_wr_data = '0;

    fm_distinct_count_sketch i_dut (.*);

    always #5 aclk = ~aclk;

    // shadow copy of the sketch
    logic [60:0] seed_mem [N_SLOTS];
    bit          seed_set [N_SLOTS];
    logic [6:0]  max_rank [N_CNT];
    logic [4:0]  inner_reg = INNER_RST;
    logic [4:0]  outer_reg = OUTER_RST;
    logic [15:0] corr_reg  = CORR_RST;

    est_t   pending_est[$];
    int     n_mismatch = 0;
    int     n_results = 0;
    int     n_adds = 0;
    int     n_items = 0;
    bit     no_stall = 1'b0;

    function automatic int eff_count(logic [4:0] v);
        if (v == 0) return 1;
        if (v > 16) return 16;
        return int'(v);
    endfunction

    function automatic logic [6:0] hash_rank(logic [60:0] a, logic [60:0] b, logic [63:0] x);
        logic [63:0] h;
        int n;
        h = 64'(a) * x + 64'(b);
        h = h % MOD_P;
        h ^= h >> FMIX_SH;
        h = h * FMIX_C1;
        h ^= h >> FMIX_SH;
        h = h * FMIX_C2;
        h ^= h >> FMIX_SH;
        if (h == 0) return RANK_ZERO;
        n = 0;
        while (!h[63]) begin
            h <<= 1;
            n++;
        end
        return 7'(n + 1);
    endfunction

    // median over groups of corrected harmonic-style group estimates
    function automatic est_t median_estimate();
        logic [63:0] grp[$];
        logic [63:0] numer, sum, v1, v2;
        est_t r;
        int k, l;
        k = eff_count(inner_reg);
        l = eff_count(outer_reg);
        r.sat = 1'b0;
        numer = (64'(corr_reg) * 64'(k)) << 32;
        for (int g = 0; g < l; g++) begin
            sum = 0;
            for (int c = 0; c < k; c++)
                if (max_rank[g * k + c] <= RANK_TERM_MAX)
                    sum += 64'd1 << (32 - max_rank[g * k + c]);
            if (sum == 0) begin
                grp.push_back({64{1'b1}});
                r.sat = 1'b1;
            end else begin
                grp.push_back(numer / sum);
            end
        end
        grp.sort();
        if (l % 2) begin
            r.estimate = grp[l / 2];
        end else begin
            v1 = grp[l / 2 - 1];
            v2 = grp[l / 2];
            r.estimate = (v1 >> 1) + (v2 >> 1) + (v1 & v2 & 64'd1);
        end
        return r;
    endfunction

    // update the shadow state for one accepted transaction
    task automatic track_item(logic [1:0] f, logic [8:0] slot, logic [60:0] seed,
                              logic [63:0] x, bit typed, est_t want);
        logic [6:0] z;
        int kl;
        n_items++;
        kl = eff_count(inner_reg) * eff_count(outer_reg);
        case (f)
            FUNC_LOAD: begin
                seed_mem[slot] = slot[0] ? seed : (seed | 61'd1);
                seed_set[slot] = 1'b1;
            end
            FUNC_ADD: begin
                n_adds++;
                for (int n = 0; n < kl; n++) begin
                    z = hash_rank(seed_mem[2 * n], seed_mem[2 * n + 1], x);
                    if (z > max_rank[n]) max_rank[n] = z;
                end
            end
            FUNC_EST: begin
                pending_est.push_back(typed ? want : median_estimate());
            end
            default: ;
        endcase
    endtask

    // present one transaction and hold it until accepted
    task automatic send(logic [1:0] f, logic [8:0] slot, logic [60:0] seed,
                        logic [63:0] x, bit typed = 0, est_t want = '0);
        if (!no_stall && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_seed_index <= slot;
        s_seed_value <= seed;
        s_item_value <= x;
        do @(posedge aclk); while (!s_ready);
        track_item(f, slot, seed, x, typed, want);
    endtask

    // register write, only with the block idle
    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        int kl;
        kl = eff_count(inner_reg) * eff_count(outer_reg);
        s_valid <= 1'b0;
        while (pending_est.size() != 0) @(posedge aclk);
        repeat (32 * kl + 100) @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_INNER: inner_reg = data[4:0];
            CFG_OUTER: outer_reg = data[4:0];
            CFG_CORR:  corr_reg  = data;
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand_elem();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [60:0] rand_seed();
        case ($urandom_range(9))
            0: return 61'd1;
            1: return SEED_ONES - 61'($urandom_range(2));
            default: return 61'({$urandom, $urandom});
        endcase
    endfunction

    // result side: random backpressure and in-order compare
    always @(posedge aclk) begin
        est_t want;
        m_ready <= no_stall || ($urandom_range(99) >= 36);
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_est.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected estimate %h sat %b", m_estimate_q16, m_saturated);
            end else begin
                want = pending_est.pop_front();
                if (m_estimate_q16 !== want.estimate || m_saturated !== want.sat) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR: estimate exp %h/%b got %h/%b", want.estimate,
                                 want.sat, m_estimate_q16, m_saturated);
                end
            end
        end
    end

    // watchdog
    initial begin
        #200ms;
        $display("Simulation FAILED");
        $finish;
    end

    row_t dir_rows[$];

    initial begin
        int k, l, kl, pick, n_phase;
        logic [4:0] p_inner [7] = '{5'd1, 5'd2, 5'd4, 5'd31, 5'd0, 5'd3, 5'd16};
        logic [4:0] p_outer [7] = '{5'd1, 5'd3, 5'd4, 5'd0, 5'd31, 5'd5, 5'd16};
        int         p_items [7] = '{60, 55, 50, 45, 45, 50, 35};
        logic [15:0] corr;

        for (int i = 0; i < N_SLOTS; i++) begin
            seed_mem[i] = '0;
            seed_set[i] = 1'b0;
        end
        for (int i = 0; i < N_CNT; i++) max_rank[i] = '0;

        // directed rows: fresh-state estimate, ignored code, seed extremes, clamped sizes
        dir_rows = '{
            '{0, FUNC_EST,  9'd0,   61'd0,             64'd0, 1, '{64'(CORR_RST), 1'b0}},
            '{0, FUNC_NOP,  9'd5,   61'd7,             '1,    0, '0},
            '{0, FUNC_LOAD, 9'd0,   61'd0,             64'd0, 0, '0},
            '{0, FUNC_LOAD, 9'd1,   SEED_ONES,         64'd0, 0, '0},
            '{0, FUNC_LOAD, 9'd2,   SEED_ONES - 61'd1, 64'd0, 0, '0},
            '{0, FUNC_LOAD, 9'd3,   61'd0,             64'd0, 0, '0},
            '{0, FUNC_LOAD, 9'd511, SEED_ONES,         64'd0, 0, '0},
            '{0, FUNC_LOAD, 9'd510, 61'd0,             64'd0, 0, '0},
            '{0, FUNC_EST,  9'd0,   61'd0,             64'd0, 1, '{64'(CORR_RST), 1'b0}},
            '{1, CFG_INNER, 9'd0,   61'd0,             64'd0, 0, '0},
            '{1, CFG_OUTER, 9'd0,   61'd2,             64'd0, 0, '0},
            '{0, FUNC_ADD,  9'd0,   61'd0,             64'd0, 0, '0},
            '{0, FUNC_ADD,  9'd0,   61'd0,             '1,    0, '0},
            '{0, FUNC_EST,  9'd0,   61'd0,             64'd0, 0, '0},
            '{1, CFG_CORR,  9'd0,   61'd0,             64'd0, 0, '0},
            '{0, FUNC_ADD,  9'd0,   61'd0,             64'h8000_0000_0000_0000, 0, '0},
            '{0, FUNC_EST,  9'd0,   61'd0,             64'd0, 0, '0},
            '{1, CFG_NONE,  9'd0,   61'hFFFF,          64'd0, 0, '0},
            '{1, CFG_CORR,  9'd0,   61'hFFFF,          64'd0, 0, '0},
            '{0, FUNC_EST,  9'd0,   61'd0,             64'd0, 0, '0}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (N_CNT + 20) @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].func_or_reg, dir_rows[i].seed[15:0]);
            else
                send(dir_rows[i].func_or_reg, dir_rows[i].slot, dir_rows[i].seed,
                     dir_rows[i].elem, dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases, sizes from the smallest to the clamped extremes
        for (int p = 0; p < 7; p++) begin
            corr = (p == 2) ? 16'hFFFF : (p == 6) ? CORR_RST : 16'($urandom);
            write_reg(CFG_INNER, {11'($urandom), p_inner[p]});
            write_reg(CFG_OUTER, {11'($urandom), p_outer[p]});
            write_reg(CFG_CORR, corr);
            no_stall = (p == 2);
            k = eff_count(inner_reg);
            l = eff_count(outer_reg);
            kl = k * l;
            // every seed an add will read must be loaded first
            for (int s = 0; s < 2 * kl; s++)
                if (!seed_set[s] || $urandom_range(3) == 0)
                    send(FUNC_LOAD, 9'(s), rand_seed(), '0);
            n_phase = 0;
            while (n_phase < p_items[p]) begin
                pick = $urandom_range(99);
                if (pick < 12)
                    send(FUNC_LOAD, 9'($urandom_range(N_SLOTS - 1)), rand_seed(), rand_elem());
                else if (pick < 16)
                    send(FUNC_NOP, 9'($urandom), 61'({$urandom, $urandom}), rand_elem());
                else if (pick < 36)
                    send(FUNC_EST, 9'($urandom), 61'({$urandom, $urandom}), rand_elem());
                else if (kl > 64 && pick < 80)
                    send(FUNC_EST, '0, '0, '0);
                else
                    send(FUNC_ADD, 9'($urandom), 61'({$urandom, $urandom}), rand_elem());
                n_phase++;
            end
            send(FUNC_EST, '0, '0, '0);
        end

        // drain
        s_valid <= 1'b0;
        no_stall = 1'b0;
        while (pending_est.size() != 0) @(posedge aclk);
        repeat (32 * eff_count(inner_reg) * eff_count(outer_reg) + 200) @(posedge aclk);

        $display("Covered %0d transactions (%0d adds), %0d estimates checked.",
                 n_items, n_adds, n_results);
        $display("Sizes from 1x1 to 16x16 incl. clamped 0/31 settings; %0d mismatches.",
                 n_mismatch);
        if (n_mismatch == 0 && pending_est.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
